>>> sv/arf_pkg.sv
// ----------------------------------------------------------------------------
// arf_pkg
// Shared types and constants for the 8-bit ALU execute unit.
// ----------------------------------------------------------------------------
`default_nettype none

package arf_pkg;

  localparam int unsigned DataW          = 8;
  localparam int unsigned FlagW          = 5;
  localparam int unsigned OpW            = 4;
  localparam int unsigned RegCodeW       = 2;
  localparam int unsigned NumRegsDefault = 4;

  // flag bit positions
  localparam int unsigned FlagC = 0;
  localparam int unsigned FlagZ = 1;
  localparam int unsigned FlagS = 2;
  localparam int unsigned FlagO = 3;
  localparam int unsigned FlagL = 4;

  localparam logic [DataW-1:0] ShiftMask = 8'h07;

  typedef enum logic [OpW-1:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_CMP   = 4'd2,
    OP_AND   = 4'd3,
    OP_OR    = 4'd4,
    OP_NOT   = 4'd5,
    OP_RSH   = 4'd6,
    OP_INC   = 4'd7,
    OP_DEC   = 4'd8,
    OP_COPY  = 4'd9,
    OP_ADDI  = 4'd10,
    OP_LOAD  = 4'd11,
    OP_STORE = 4'd12
  } op_e;

  typedef struct packed {
    logic [DataW-1:0] value;
    logic [FlagW-1:0] flags;
    logic             reg_we;
    logic             store;
    logic [DataW-1:0] store_addr;
    logic [DataW-1:0] store_data;
  } alu_res_t;

endpackage

`default_nettype wire

>>> sv/arf_ram.sv
// ----------------------------------------------------------------------------
// arf_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module arf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_a_i,
  input  wire logic [AddrW-1:0] raddr_b_i,
  output logic      [Width-1:0] rdata_a_o,
  output logic      [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

`default_nettype wire

>>> sv/arf_alu.sv
// ----------------------------------------------------------------------------
// arf_alu
// Combinational ALU: result value, new flags, register write enable and store request.
// ----------------------------------------------------------------------------
`default_nettype none

module arf_alu (
  input  wire logic [arf_pkg::OpW-1:0]   op_i,
  input  wire logic [arf_pkg::DataW-1:0] x_i,
  input  wire logic [arf_pkg::DataW-1:0] y_i,
  input  wire logic [arf_pkg::DataW-1:0] imm_i,
  input  wire logic [arf_pkg::FlagW-1:0] flags_i,
  output arf_pkg::alu_res_t              res_o
);

  localparam int unsigned W = arf_pkg::DataW;

  arf_pkg::op_e   op;
  logic [W-1:0]   add_b;
  logic [W:0]     sum;
  logic [W:0]     diff;
  logic           add_ovf;
  logic           sub_ovf;
  logic [W-1:0]   shamt;
  logic [W-1:0]   rsh;
  logic [arf_pkg::FlagW-1:0] add_flags;
  logic [arf_pkg::FlagW-1:0] sub_flags;

  assign op    = arf_pkg::op_e'(op_i);
  assign add_b = (op == arf_pkg::OP_ADDI) ? imm_i : y_i;
  assign sum   = {1'b0, x_i} + {1'b0, add_b};
  assign diff  = {1'b0, x_i} - {1'b0, y_i};
  assign shamt = y_i & arf_pkg::ShiftMask;
  assign rsh   = x_i >> shamt;

  assign add_ovf = (x_i[W-1] == add_b[W-1]) && (sum[W-1] != x_i[W-1]);
  assign sub_ovf = (x_i[W-1] != y_i[W-1]) && (diff[W-1] != x_i[W-1]);

  always_comb begin
    add_flags = '0;
    add_flags[arf_pkg::FlagC] = sum[W];
    add_flags[arf_pkg::FlagZ] = (sum[W-1:0] == '0);
    add_flags[arf_pkg::FlagS] = sum[W-1];
    add_flags[arf_pkg::FlagO] = add_ovf;
    add_flags[arf_pkg::FlagL] = sum[W-1] ^ add_ovf;

    sub_flags = '0;
    sub_flags[arf_pkg::FlagC] = diff[W];  // borrow
    sub_flags[arf_pkg::FlagZ] = (diff[W-1:0] == '0);
    sub_flags[arf_pkg::FlagS] = diff[W-1];
    sub_flags[arf_pkg::FlagO] = sub_ovf;
    sub_flags[arf_pkg::FlagL] = diff[W-1] ^ sub_ovf;
  end

  // Z, S and L=S for logic ops, C and O cleared
  function automatic logic [arf_pkg::FlagW-1:0] logic_flags(input logic [W-1:0] r);
    logic [arf_pkg::FlagW-1:0] f;
    f = '0;
    f[arf_pkg::FlagZ] = (r == '0);
    f[arf_pkg::FlagS] = r[W-1];
    f[arf_pkg::FlagL] = r[W-1];
    return f;
  endfunction

  always_comb begin
    res_o            = '0;
    res_o.flags      = flags_i;
    res_o.reg_we     = 1'b1;
    case (op)
      arf_pkg::OP_ADD, arf_pkg::OP_ADDI: begin
        res_o.value = sum[W-1:0];
        res_o.flags = add_flags;
      end
      arf_pkg::OP_SUB: begin
        res_o.value = diff[W-1:0];
        res_o.flags = sub_flags;
      end
      arf_pkg::OP_CMP: begin
        res_o.value  = diff[W-1:0];
        res_o.flags  = sub_flags;
        res_o.reg_we = 1'b0;
      end
      arf_pkg::OP_AND: begin
        res_o.value = x_i & y_i;
        res_o.flags = logic_flags(x_i & y_i);
      end
      arf_pkg::OP_OR: begin
        res_o.value = x_i | y_i;
        res_o.flags = logic_flags(x_i | y_i);
      end
      arf_pkg::OP_NOT:  res_o.value = ~x_i;
      arf_pkg::OP_RSH: begin
        res_o.value = rsh;
        res_o.flags = logic_flags(rsh);
      end
      arf_pkg::OP_INC:  res_o.value = x_i + W'(1);
      arf_pkg::OP_DEC:  res_o.value = x_i - W'(1);
      arf_pkg::OP_COPY: res_o.value = y_i;
      arf_pkg::OP_LOAD: res_o.value = imm_i;
      arf_pkg::OP_STORE: begin
        res_o.reg_we     = 1'b0;
        res_o.store      = 1'b1;
        res_o.store_addr = y_i;
        res_o.store_data = x_i;
      end
      default: res_o.reg_we = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

>>> sv/alu_regfile_flags_execute.sv
// Pipeline: register file read stage, then ALU stage into the result register.
// Throughput: one transaction per cycle unless the output stalls; the register
// file write of one item is forwarded to the read of the next, so dependent
// items do not stall.
// Reset: all registers read as zero (per-entry valid bits), flags cleared,
// both pipeline stages emptied.
// ----------------------------------------------------------------------------
// alu_regfile_flags_execute
// Execute unit of a tiny 8-bit processor: register file, flags and ALU.
// ----------------------------------------------------------------------------
`default_nettype none

module alu_regfile_flags_execute #(
  parameter int unsigned NUM_REGS = arf_pkg::NumRegsDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [arf_pkg::OpW-1:0]        req_type_i,
  input  wire logic [arf_pkg::RegCodeW-1:0]   dest_reg_i,
  input  wire logic [arf_pkg::RegCodeW-1:0]   src_reg_i,
  input  wire logic [arf_pkg::DataW-1:0]      immediate_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic      [arf_pkg::DataW-1:0]      result_value_o,
  output logic      [arf_pkg::FlagW-1:0]      flags_out_o,
  output logic                                store_valid_o,
  output logic      [arf_pkg::DataW-1:0]      store_addr_o,
  output logic      [arf_pkg::DataW-1:0]      store_data_o
);

  localparam int unsigned IdxW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int unsigned W    = arf_pkg::DataW;

  // register code wraps modulo NUM_REGS; code < 4 <= 2*NUM_REGS
  function automatic logic [IdxW-1:0] wrap_idx(input logic [arf_pkg::RegCodeW-1:0] code);
    logic [arf_pkg::RegCodeW-1:0] w;
    if (int'(code) >= int'(NUM_REGS)) begin
      w = arf_pkg::RegCodeW'(int'(code) - int'(NUM_REGS));
    end else begin
      w = code;
    end
    return IdxW'(w);
  endfunction

  logic                       accept;
  logic                       adv;
  logic [IdxW-1:0]            xi_new;
  logic [IdxW-1:0]            yi_new;

  // read stage
  logic                       s1_valid_q;
  logic [arf_pkg::OpW-1:0]    s1_op_q;
  logic [IdxW-1:0]            s1_xi_q;
  logic [W-1:0]               s1_imm_q;
  logic                       x_ovr_q, y_ovr_q;
  logic [W-1:0]               x_ovr_dat_q, y_ovr_dat_q;
  logic [W-1:0]               ram_x, ram_y;
  logic [W-1:0]               x_val, y_val;

  logic [NUM_REGS-1:0]        reg_vld_q;
  logic [arf_pkg::FlagW-1:0]  flags_q;

  arf_pkg::alu_res_t          res;
  logic                       rf_we;

  // result register
  logic                       out_valid_q;
  arf_pkg::alu_res_t          out_q;

  assign adv        = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv;
  assign accept     = in_valid_i && in_ready_o;
  assign xi_new     = wrap_idx(dest_reg_i);
  assign yi_new     = wrap_idx(src_reg_i);
  assign rf_we      = adv && res.reg_we;

  arf_ram #(
    .Width (W),
    .Depth (NUM_REGS)
  ) u_rf (
    .clk_i     (clk_i),
    .we_i      (rf_we),
    .waddr_i   (s1_xi_q),
    .wdata_i   (res.value),
    .re_i      (accept),
    .raddr_a_i (xi_new),
    .raddr_b_i (yi_new),
    .rdata_a_o (ram_x),
    .rdata_b_o (ram_y)
  );

  assign x_val = x_ovr_q ? x_ovr_dat_q : ram_x;
  assign y_val = y_ovr_q ? y_ovr_dat_q : ram_y;

  arf_alu u_alu (
    .op_i    (s1_op_q),
    .x_i     (x_val),
    .y_i     (y_val),
    .imm_i   (s1_imm_q),
    .flags_i (flags_q),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      reg_vld_q   <= '0;
      flags_q     <= '0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
        flags_q     <= res.flags;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (rf_we) begin
        reg_vld_q[s1_xi_q] <= 1'b1;
      end
    end
  end

  // operand override: forward a same-cycle write, or zero for an unwritten entry
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q  <= req_type_i;
      s1_xi_q  <= xi_new;
      s1_imm_q <= immediate_i;
      if (rf_we && s1_xi_q == xi_new) begin
        x_ovr_q     <= 1'b1;
        x_ovr_dat_q <= res.value;
      end else begin
        x_ovr_q     <= !reg_vld_q[xi_new];
        x_ovr_dat_q <= '0;
      end
      if (rf_we && s1_xi_q == yi_new) begin
        y_ovr_q     <= 1'b1;
        y_ovr_dat_q <= res.value;
      end else begin
        y_ovr_q     <= !reg_vld_q[yi_new];
        y_ovr_dat_q <= '0;
      end
    end
    if (adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_q.value;
  assign flags_out_o    = out_q.flags;
  assign store_valid_o  = out_q.store;
  assign store_addr_o   = out_q.store_addr;
  assign store_data_o   = out_q.store_data;

endmodule

`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 8-bit ALU execute unit. A driver issues
// transactions from a queue. A predictor keeps its own register file and
// flags, and computes each result when its transaction is accepted. A monitor
// compares the results in order under several sender and receiver idle mixes.
// ----------------------------------------------------------------------------

module tb;

  localparam int unsigned HoldCycles = 200;
  localparam logic [arf_pkg::OpW-1:0] OpCodeMax = {arf_pkg::OpW{1'b1}};

  typedef struct packed {
    logic [arf_pkg::OpW-1:0]      op;
    logic [arf_pkg::RegCodeW-1:0] dst;
    logic [arf_pkg::RegCodeW-1:0] src;
    logic [arf_pkg::DataW-1:0]    imm;
  } exec_req_t;

  typedef struct packed {
    logic [arf_pkg::DataW-1:0] value;
    logic [arf_pkg::FlagW-1:0] flags;
    logic                      st_valid;
    logic [arf_pkg::DataW-1:0] st_addr;
    logic [arf_pkg::DataW-1:0] st_data;
  } exec_res_t;

  logic                         clk_i = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [arf_pkg::OpW-1:0]      req_type = '0;
  logic [arf_pkg::RegCodeW-1:0] dest_reg = '0;
  logic [arf_pkg::RegCodeW-1:0] src_reg = '0;
  logic [arf_pkg::DataW-1:0]    immediate = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [arf_pkg::DataW-1:0]    result_value;
  logic [arf_pkg::FlagW-1:0]    flags_out;
  logic                         store_valid;
  logic [arf_pkg::DataW-1:0]    store_addr;
  logic [arf_pkg::DataW-1:0]    store_data;

  exec_req_t issue_q[$];
  exec_res_t result_q[$];
  exec_req_t next_req;
  exec_res_t got_res;
  exec_res_t want_res;

  // predictor state
  logic [arf_pkg::DataW-1:0] gpr [arf_pkg::NumRegsDefault];
  logic [arf_pkg::FlagW-1:0] cur_flags;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_req = 1'b0;
  int unsigned hold_cnt = 0;
  int unsigned errors = 0;

  alu_regfile_flags_execute dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .req_type_i    (req_type),
    .dest_reg_i    (dest_reg),
    .src_reg_i     (src_reg),
    .immediate_i   (immediate),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .result_value_o(result_value),
    .flags_out_o   (flags_out),
    .store_valid_o (store_valid),
    .store_addr_o  (store_addr),
    .store_data_o  (store_data)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [arf_pkg::FlagW-1:0] arith_flags(
      input logic [arf_pkg::DataW-1:0] a,
      input logic [arf_pkg::DataW-1:0] b,
      input logic [arf_pkg::DataW-1:0] r,
      input logic                      is_sub);
    logic [arf_pkg::FlagW-1:0] f;
    f = '0;
    f[arf_pkg::FlagZ] = (r == '0);
    f[arf_pkg::FlagS] = r[arf_pkg::DataW-1];
    if (is_sub) begin
      f[arf_pkg::FlagC] = (a < b);
      f[arf_pkg::FlagO] = (a[arf_pkg::DataW-1] != b[arf_pkg::DataW-1]) &&
                          (r[arf_pkg::DataW-1] != a[arf_pkg::DataW-1]);
    end else begin
      f[arf_pkg::FlagC] = ({1'b0, a} + {1'b0, b}) > {1'b0, {arf_pkg::DataW{1'b1}}};
      f[arf_pkg::FlagO] = (a[arf_pkg::DataW-1] == b[arf_pkg::DataW-1]) &&
                          (r[arf_pkg::DataW-1] != a[arf_pkg::DataW-1]);
    end
    f[arf_pkg::FlagL] = f[arf_pkg::FlagS] ^ f[arf_pkg::FlagO];
    return f;
  endfunction

  function automatic logic [arf_pkg::FlagW-1:0] logic_flags(
      input logic [arf_pkg::DataW-1:0] r);
    logic [arf_pkg::FlagW-1:0] f;
    f = '0;
    f[arf_pkg::FlagZ] = (r == '0);
    f[arf_pkg::FlagS] = r[arf_pkg::DataW-1];
    f[arf_pkg::FlagL] = r[arf_pkg::DataW-1];
    return f;
  endfunction

  // Executes one transaction against the predictor state and returns its result.
  function automatic exec_res_t execute_op(input exec_req_t q);
    logic [arf_pkg::DataW-1:0] x;
    logic [arf_pkg::DataW-1:0] y;
    logic [arf_pkg::DataW-1:0] b;
    logic [arf_pkg::DataW-1:0] r;
    logic                      wr;
    exec_res_t                 res;
    x   = gpr[q.dst];
    y   = gpr[q.src];
    r   = '0;
    wr  = 1'b1;
    res = '0;
    case (q.op)
      arf_pkg::OP_ADD, arf_pkg::OP_ADDI: begin
        b = (q.op == arf_pkg::OP_ADDI) ? q.imm : y;
        r = x + b;
        cur_flags = arith_flags(x, b, r, 1'b0);
      end
      arf_pkg::OP_SUB, arf_pkg::OP_CMP: begin
        r = x - y;
        cur_flags = arith_flags(x, y, r, 1'b1);
        wr = (q.op == arf_pkg::OP_SUB);
      end
      arf_pkg::OP_AND: begin
        r = x & y;
        cur_flags = logic_flags(r);
      end
      arf_pkg::OP_OR: begin
        r = x | y;
        cur_flags = logic_flags(r);
      end
      arf_pkg::OP_NOT:  r = ~x;
      arf_pkg::OP_RSH: begin
        r = x >> (y & arf_pkg::ShiftMask);
        cur_flags = logic_flags(r);
      end
      arf_pkg::OP_INC:  r = x + arf_pkg::DataW'(1);
      arf_pkg::OP_DEC:  r = x - arf_pkg::DataW'(1);
      arf_pkg::OP_COPY: r = y;
      arf_pkg::OP_LOAD: r = q.imm;
      arf_pkg::OP_STORE: begin
        wr = 1'b0;
        res.st_valid = 1'b1;
        res.st_addr  = y;
        res.st_data  = x;
      end
      default: wr = 1'b0;
    endcase
    if (wr) gpr[q.dst] = r;
    res.value = r;
    res.flags = cur_flags;
    return res;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        result_q.push_back(execute_op({req_type, dest_reg, src_reg, immediate}));
      end
      if (issue_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_req = issue_q.pop_front();
        req_type  <= next_req.op;
        dest_reg  <= next_req.dst;
        src_reg   <= next_req.src;
        immediate <= next_req.imm;
        in_valid  <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver backpressure; the long hold-off is counted here
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req && hold_cnt < HoldCycles) begin
      hold_cnt  <= hold_cnt + 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  // monitor
  always @(posedge clk_i) begin
    if (rst_n && out_valid && out_ready) begin
      got_res = {result_value, flags_out, store_valid, store_addr, store_data};
      if (result_q.size() == 0) begin
        $error("unexpected result transaction: value 0x%0h", result_value);
        errors++;
      end else begin
        want_res = result_q.pop_front();
        check_field("result_value", want_res.value, got_res.value);
        check_field("flags_out", want_res.flags, got_res.flags);
        check_field("store_valid", want_res.st_valid, got_res.st_valid);
        check_field("store_addr", want_res.st_addr, got_res.st_addr);
        check_field("store_data", want_res.st_data, got_res.st_data);
      end
    end
  end

  task automatic push_req(input logic [arf_pkg::OpW-1:0] op,
                          input logic [arf_pkg::RegCodeW-1:0] d,
                          input logic [arf_pkg::RegCodeW-1:0] s,
                          input logic [arf_pkg::DataW-1:0] imm);
    issue_q.push_back({op, d, s, imm});
  endtask

  function automatic logic [arf_pkg::DataW-1:0] pick_byte();
    case ($urandom_range(7))
      0:       return '0;
      1:       return {arf_pkg::DataW{1'b1}};
      2:       return {1'b1, {(arf_pkg::DataW-1){1'b0}}};
      3:       return {1'b0, {(arf_pkg::DataW-1){1'b1}}};
      default: return arf_pkg::DataW'($urandom_range(255));
    endcase
  endfunction

  // Loads seed the register file with edge and random values; a few unused codes mixed in.
  task automatic push_random(input int unsigned n);
    int unsigned               sel;
    logic [arf_pkg::OpW-1:0]   op;
    logic [arf_pkg::DataW-1:0] imm;
    repeat (n) begin
      sel = $urandom_range(99);
      imm = arf_pkg::DataW'($urandom_range(255));
      if (sel < 18) begin
        op  = arf_pkg::OP_LOAD;
        imm = pick_byte();
      end else if (sel < 22) begin
        op = arf_pkg::OpW'($urandom_range(OpCodeMax, arf_pkg::OP_STORE + 1));
      end else begin
        op = arf_pkg::OpW'($urandom_range(arf_pkg::OP_STORE));
        if (op == arf_pkg::OP_ADDI) imm = pick_byte();
      end
      push_req(op, arf_pkg::RegCodeW'($urandom_range(3)),
               arf_pkg::RegCodeW'($urandom_range(3)), imm);
    end
  endtask

  task automatic wait_drained();
    while (issue_q.size() != 0 || in_valid || result_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic run_phase(input int unsigned n, input int unsigned send_pct,
                           input int unsigned recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    push_random(n);
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < arf_pkg::NumRegsDefault; i++) gpr[i] = '0;
    cur_flags = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;

    // directed: edge values, every operation, same-register and masked shifts
    push_req(arf_pkg::OP_LOAD, 0, 0, 8'h7f);
    push_req(arf_pkg::OP_LOAD, 1, 0, 8'h01);
    push_req(arf_pkg::OP_ADD, 0, 1, 8'h00);     // signed overflow into 0x80
    push_req(arf_pkg::OP_LOAD, 2, 0, 8'hff);
    push_req(arf_pkg::OP_ADD, 2, 1, 8'h00);     // carry out, zero
    push_req(arf_pkg::OP_SUB, 1, 0, 8'h00);     // borrow and overflow
    push_req(arf_pkg::OP_CMP, 0, 0, 8'h00);
    push_req(arf_pkg::OP_LOAD, 3, 0, 8'h09);
    push_req(arf_pkg::OP_LOAD, 2, 0, 8'hf0);
    push_req(arf_pkg::OP_RSH, 2, 3, 8'h00);     // amount 9 masked to 1
    push_req(arf_pkg::OP_AND, 2, 0, 8'h00);
    push_req(arf_pkg::OP_OR, 0, 3, 8'h00);
    push_req(arf_pkg::OP_NOT, 0, 0, 8'h00);
    push_req(arf_pkg::OP_INC, 2, 0, 8'h00);
    push_req(arf_pkg::OP_DEC, 1, 0, 8'h00);
    push_req(arf_pkg::OP_COPY, 3, 0, 8'h00);
    push_req(arf_pkg::OP_ADDI, 3, 0, 8'hff);
    push_req(arf_pkg::OP_STORE, 0, 1, 8'h00);
    push_req(arf_pkg::OpW'(arf_pkg::OP_STORE + 1), 1, 2, 8'h5a);
    push_req(arf_pkg::OpW'(OpCodeMax - 1), 2, 3, 8'ha5);
    push_req(OpCodeMax, 3, 0, 8'hff);
    push_req(arf_pkg::OP_LOAD, 1, 0, 8'h00);
    push_req(arf_pkg::OP_DEC, 1, 1, 8'h00);     // wraps to 0xff
    push_req(arf_pkg::OP_RSH, 1, 1, 8'h00);     // same register as both operands
    push_req(arf_pkg::OP_SUB, 1, 1, 8'h00);
    wait_drained();

    run_phase(300, 0, 0);
    run_phase(300, 79, 0);
    run_phase(300, 0, 79);
    run_phase(300, 10, 10);

    // receiver holds off while the sender keeps issuing
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req = 1'b1;
    push_random(150);
    wait_drained();

    repeat (10) @(posedge clk_i);
    if (errors == 0 && result_q.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("tb: FAIL");
    $finish;
  end

endmodule
